@@ design/ecc_pkg.sv @@
// Shared types, constants and helpers for the exponential code converter.
`timescale 1ns / 1ps
`default_nettype none
package ecc_pkg;

	localparam int unsigned MAX_EXP_BITS  = 3;
	localparam int unsigned MAX_MANT_BITS = 12;
	localparam int unsigned EXP_OFFSET    = 3;
	localparam int unsigned VAL_W         = 23;

	localparam logic [1:0] CFG_EXP_BITS  = 2'd0;
	localparam logic [1:0] CFG_MANT_BITS = 2'd1;

	typedef enum logic [1:0] {
		K_ENC_PASS = 2'd0,
		K_ENC      = 2'd1,
		K_DEC_PASS = 2'd2,
		K_DEC      = 2'd3
	} kind_t;

	typedef struct packed {
		logic        action;
		logic [31:0] value;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic [VAL_W-1:0] effective_value;
		logic             saturated;
	} out_t;

	typedef struct packed {
		kind_t            kind;
		logic [1:0]       e;
		logic [3:0]       m;
		logic [VAL_W-1:0] val;
		logic             sat;
	} s1_t;

	typedef struct packed {
		kind_t            kind;
		logic [1:0]       e;
		logic [3:0]       m;
		logic [VAL_W-1:0] val;
		logic             sat;
		logic [4:0]       sh;
		logic [2:0]       ex;
	} s2_t;

	function automatic logic [1:0] clamp_e(input logic [1:0] raw);
		logic [1:0] r;
		r = raw;
		if (raw == 2'd0) begin
			r = 2'd1;
		end
		return r;
	endfunction

	function automatic logic [3:0] clamp_m(input logic [3:0] raw);
		logic [3:0] r;
		r = raw;
		if (raw == 4'd0) begin
			r = 4'd1;
		end else if (raw > 4'(MAX_MANT_BITS)) begin
			r = 4'(MAX_MANT_BITS);
		end
		return r;
	endfunction

	function automatic logic [2:0] emax_of(input logic [1:0] e);
		return 3'((4'd1 << e) - 4'd1);
	endfunction

endpackage
`default_nettype wire

@@ design/ecc_classify.sv @@
// First stage: width clamp, range checks, saturation and decode masking.
`timescale 1ns / 1ps
`default_nettype none
module ecc_classify (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_in,
	input  wire ecc_pkg::in_t req,
	input  wire logic [1:0]  exp_raw,
	input  wire logic [3:0]  mant_raw,
	output logic             valid_s1,
	output ecc_pkg::s1_t     data_s1
);
	logic [1:0]  e;
	logic [3:0]  m;
	logic [4:0]  wsum;
	logic [16:0] flag;
	logic [16:0] code_mask;
	logic [16:0] code;
	logic [3:0]  eshift;
	logic [22:0] maxv;
	logic        lt;
	logic        over;
	ecc_pkg::s1_t nxt;

	always_comb begin
		e         = ecc_pkg::clamp_e(exp_raw);
		m         = ecc_pkg::clamp_m(mant_raw);
		wsum      = 5'(e) + 5'(m);
		flag      = 17'd1 << wsum;
		code_mask = (flag << 1) - 17'd1;
		code      = req.value[16:0] & code_mask;
		eshift    = 4'(ecc_pkg::emax_of(e)) + 4'(ecc_pkg::EXP_OFFSET);
		maxv      = 23'((14'd1 << (5'(m) + 5'd1)) - 14'd1) << eshift;
		lt        = req.value < 32'(flag);
		over      = req.value > 32'(maxv);
		nxt.e     = e;
		nxt.m     = m;
		nxt.sat   = 1'b0;
		if (!req.action) begin
			if (lt) begin
				nxt.kind = ecc_pkg::K_ENC_PASS;
				nxt.val  = req.value[22:0];
			end else begin
				nxt.kind = ecc_pkg::K_ENC;
				nxt.sat  = over;
				nxt.val  = over ? maxv : req.value[22:0];
			end
		end else begin
			nxt.val  = 23'(code);
			nxt.kind = ((code & flag) != 17'd0) ? ecc_pkg::K_DEC : ecc_pkg::K_DEC_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ design/ecc_locate.sv @@
// Second stage: leading-one search, mantissa shift and exponent field.
`timescale 1ns / 1ps
`default_nettype none
module ecc_locate (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         valid_s1,
	input  wire ecc_pkg::s1_t data_s1,
	output logic              valid_s2,
	output ecc_pkg::s2_t      data_s2
);
	logic [4:0]  p;
	logic [4:0]  sh_enc;
	logic [4:0]  ex_wide;
	logic [2:0]  emax;
	logic [22:0] dec_field;
	ecc_pkg::s2_t nxt;

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < ecc_pkg::VAL_W; i++) begin
			if (data_s1.val[i]) begin
				p = 5'(i);
			end
		end
		emax      = ecc_pkg::emax_of(data_s1.e);
		sh_enc    = p - 5'(data_s1.m);
		ex_wide   = sh_enc - 5'(ecc_pkg::EXP_OFFSET);
		dec_field = data_s1.val >> data_s1.m;
		nxt.kind  = data_s1.kind;
		nxt.e     = data_s1.e;
		nxt.m     = data_s1.m;
		nxt.val   = data_s1.val;
		nxt.sat   = data_s1.sat;
		if (data_s1.kind == ecc_pkg::K_ENC) begin
			nxt.sh = sh_enc;
			nxt.ex = ex_wide[2:0] & emax;
		end else begin
			nxt.sh = 5'd0;
			nxt.ex = dec_field[2:0] & emax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ design/ecc_pack.sv @@
// Third stage: mantissa extraction, code packing and value expansion.
`timescale 1ns / 1ps
`default_nettype none
module ecc_pack (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         valid_s2,
	input  wire ecc_pkg::s2_t data_s2,
	output logic              valid_s3,
	output ecc_pkg::out_t     data_s3
);
	logic [22:0] shifted;
	logic [12:0] mmask;
	logic [12:0] t;
	logic [3:0]  eshift;
	logic [22:0] expanded;
	logic [22:0] flag;
	logic [22:0] code;
	ecc_pkg::out_t nxt;

	always_comb begin
		shifted  = data_s2.val >> data_s2.sh;
		mmask    = (13'd1 << data_s2.m) - 13'd1;
		t        = (shifted[12:0] & mmask) | (13'd1 << data_s2.m);
		eshift   = 4'(data_s2.ex) + 4'(ecc_pkg::EXP_OFFSET);
		expanded = 23'(t) << eshift;
		flag     = 23'd1 << (5'(data_s2.e) + 5'(data_s2.m));
		code     = flag | (23'(data_s2.ex) << data_s2.m) | 23'(t & mmask);
		nxt.saturated = 1'b0;
		case (data_s2.kind)
			ecc_pkg::K_ENC_PASS: begin
				nxt.result_value    = data_s2.val;
				nxt.effective_value = data_s2.val;
			end
			ecc_pkg::K_ENC: begin
				nxt.result_value    = code;
				nxt.effective_value = expanded;
				nxt.saturated       = data_s2.sat;
			end
			ecc_pkg::K_DEC: begin
				nxt.result_value    = expanded;
				nxt.effective_value = 23'd0;
			end
			default: begin
				nxt.result_value    = data_s2.val;
				nxt.effective_value = 23'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			data_s3 <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ design/exponential_code_converter_core.sv @@
// Each accepted request passes through the classify, locate and pack stage registers; done is the pack stage's valid.
// Throughput: one transaction per cycle through three register stages; busy stays low.
// Each result is held on rsp for exactly one cycle with done high.
// Reset clears all stage valid bits and sets exp_bits to 3 and mant_bits to 12.
// Configuration writes are taken on any cycle; cfg_ready stays high.
`timescale 1ns / 1ps
`default_nettype none
module exponential_code_converter_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire ecc_pkg::in_t req,
	output logic              done,
	output ecc_pkg::out_t     rsp,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [3:0]   cfg_data
);
	logic [1:0]   exp_bits_q;
	logic [3:0]   mant_bits_q;
	logic         valid_s1;
	logic         valid_s2;
	ecc_pkg::s1_t data_s1;
	ecc_pkg::s2_t data_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_bits_q  <= 2'd3;
			mant_bits_q <= 4'd12;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ecc_pkg::CFG_EXP_BITS) begin
				exp_bits_q <= cfg_data[1:0];
			end else if (cfg_index == ecc_pkg::CFG_MANT_BITS) begin
				mant_bits_q <= cfg_data;
			end
		end
	end

	ecc_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start && !busy),
		.req      (req),
		.exp_raw  (exp_bits_q),
		.mant_raw (mant_bits_q),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	ecc_locate u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	ecc_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (done),
		.data_s3  (rsp)
	);

endmodule
`default_nettype wire
